>>> hdl/sra_pkg.sv
// Shared constants and types of the sparse row accumulator.
`default_nettype none

package sra_pkg;

	// Number of accumulated columns and the widths that follow from it.
	localparam int COLUMNS = 64;
	localparam int OFF_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int LINK_W  = $clog2(COLUMNS + 2);
	localparam int COUNT_W = $clog2(COLUMNS + 1);

	// Link codes: 0..COLUMNS-1 name the next offset, END_CODE closes the list.
	localparam logic [LINK_W-1:0] END_CODE = LINK_W'(COLUMNS);

	// Q16.16 data width and the rounding constant of the product.
	localparam int DATA_W = 32;
	localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

	// Configuration register indexes.
	localparam logic REG_SORTED_MODE = 1'b0;
	localparam logic REG_COLUMN_BASE = 1'b1;

	// Input operations.
	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_RETRIEVE = 2'd1,
		OP_CLEAR    = 2'd2
	} opcode_t;

endpackage

`default_nettype wire

>>> hdl/sparse_row_accumulator.sv
// Sparse row accumulator: dense value memory threaded by a linked list of occupied columns.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------------------
//  input    | in        | in_valid / in_stall    | opcode, column, entry_value, coefficient
//  output   | out       | out_valid / out_stall  | out_column, out_value, has_entry, last
//  config   | in        | cfg_we                 | cfg_index, cfg_data
//
// An add rounds in S_RND and ends there when its column is out of range; S_ACC accumulates
// or links at the list head; a sorted insert at the front goes on to S_INS, any other walks
// one entry per S_SWALK step, then S_INS and S_INS_PREV. A retrieve passes S_RSTART, S_RDATA
// per list entry and S_RFIN for the final result; a clear and an unused opcode finish in
// S_IDLE. Reset clears the occupancy flags in flip-flops at once, so no clearing pass is needed.
// A held result in the output register stalls a retrieve only when the next result is ready.
`default_nettype none

module sparse_row_accumulator
	import sra_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	// Configuration port
	input  wire                     cfg_we,
	input  wire                     cfg_index,
	input  wire [DATA_W-1:0]        cfg_data,
	// Input channel
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire [1:0]               opcode,
	input  wire [31:0]              column,
	input  wire signed [DATA_W-1:0] entry_value,
	input  wire signed [DATA_W-1:0] coefficient,
	// Output channel
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [31:0]             out_column,
	output logic signed [DATA_W-1:0] out_value,
	output logic                    has_entry,
	output logic                    last
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_RND      = 9'b000000010,
		S_ACC      = 9'b000000100,
		S_SWALK    = 9'b000001000,
		S_INS      = 9'b000010000,
		S_INS_PREV = 9'b000100000,
		S_RSTART   = 9'b001000000,
		S_RDATA    = 9'b010000000,
		S_RFIN     = 9'b100000000
	} state_t;

	// Round half up from Q32.32 to Q16.16 and saturate.
	function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = (p + ROUND_HALF) >>> 16;
		if ((r[63:31] == '0) || (r[63:31] == '1)) begin
			return r[31:0];
		end else if (r[63]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

	// Saturating signed add.
	function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b);
		logic signed [DATA_W:0] s;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s[DATA_W] == s[DATA_W-1]) begin
			return s[DATA_W-1:0];
		end else if (s[DATA_W]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

	// Control state.
	state_t              state_q;
	logic                sorted_q;
	logic [31:0]         base_q;
	logic [LINK_W-1:0]   head_q;
	logic [COUNT_W-1:0]  count_q;
	logic [COLUMNS-1:0]  occ_q;
	logic                has_prev_q;
	logic                pend_valid_q;
	logic                out_valid_q;

	// Working registers of the current transaction.
	logic signed [63:0]       prod_s1;
	logic signed [DATA_W-1:0] prod_q;
	logic [31:0]              off_full_q;
	logic [LINK_W-1:0]        cur_q;
	logic [OFF_W-1:0]         prev_q;
	logic [31:0]              pend_col_q;
	logic signed [DATA_W-1:0] pend_val_q;
	logic [31:0]              out_column_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic                     has_entry_q;
	logic                     last_q;

	// Memories and their ports.
	logic signed [DATA_W-1:0] value_mem [COLUMNS];
	logic [LINK_W-1:0]        link_mem  [COLUMNS];
	logic signed [DATA_W-1:0] val_rdata_q;
	logic [LINK_W-1:0]        link_rdata_q;
	logic                     rd_en;
	logic [OFF_W-1:0]         rd_addr;
	logic                     val_we;
	logic [OFF_W-1:0]         val_waddr;
	logic signed [DATA_W-1:0] val_wdata;
	logic                     link_we;
	logic [OFF_W-1:0]         link_waddr;
	logic [LINK_W-1:0]        link_wdata;

	// Derived values.
	logic [OFF_W-1:0] off_idx;
	logic             in_range;
	logic             accept;
	logic             out_free;
	logic             rd_nonzero;
	logic             rd_blocked;
	logic             head_stop;
	logic             link_stop;
	logic             out_push;
	logic [31:0]      push_column;
	logic signed [DATA_W-1:0] push_value;
	logic             push_has;
	logic             push_last;

	assign off_idx    = off_full_q[OFF_W-1:0];
	assign in_range   = off_full_q < 32'(COLUMNS);
	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign rd_nonzero = (val_rdata_q != '0);
	assign rd_blocked = rd_nonzero && pend_valid_q && !out_free;
	// A sorted walk stops at the first link not below the new offset; the end code always is.
	assign head_stop  = (head_q >= LINK_W'(off_idx));
	assign link_stop  = (link_rdata_q >= LINK_W'(off_idx));

	assign out_valid  = out_valid_q;
	assign out_column = out_column_q;
	assign out_value  = out_value_q;
	assign has_entry  = has_entry_q;
	assign last       = last_q;

	// Memory port selection for each state.
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = off_idx;
		val_we     = 1'b0;
		val_waddr  = off_idx;
		val_wdata  = prod_q;
		link_we    = 1'b0;
		link_waddr = off_idx;
		link_wdata = cur_q;
		unique case (state_q)
			S_RND: begin
				rd_en = in_range;
			end
			S_ACC: begin
				if (occ_q[off_idx]) begin
					val_we    = 1'b1;
					val_wdata = sat_add(val_rdata_q, prod_q);
				end else if (!sorted_q) begin
					val_we     = 1'b1;
					link_we    = 1'b1;
					link_wdata = head_q;
				end else if (!head_stop) begin
					rd_en   = 1'b1;
					rd_addr = head_q[OFF_W-1:0];
				end
			end
			S_SWALK: begin
				if (!link_stop) begin
					rd_en   = 1'b1;
					rd_addr = link_rdata_q[OFF_W-1:0];
				end
			end
			S_INS: begin
				val_we  = 1'b1;
				link_we = 1'b1;
			end
			S_INS_PREV: begin
				link_we    = 1'b1;
				link_waddr = prev_q;
				link_wdata = LINK_W'(off_idx);
			end
			S_RSTART: begin
				rd_en   = (head_q < END_CODE);
				rd_addr = head_q[OFF_W-1:0];
			end
			S_RDATA: begin
				rd_en   = !rd_blocked && (link_rdata_q < END_CODE);
				rd_addr = link_rdata_q[OFF_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Result selection: a pending entry goes out once the next one is found or the walk ends.
	always_comb begin
		out_push    = 1'b0;
		push_column = pend_col_q;
		push_value  = pend_val_q;
		push_has    = 1'b1;
		push_last   = 1'b0;
		if (state_q == S_RDATA) begin
			out_push = !rd_blocked && rd_nonzero && pend_valid_q;
		end else if (state_q == S_RFIN) begin
			out_push  = out_free;
			push_last = 1'b1;
			if (!pend_valid_q) begin
				push_column = '0;
				push_value  = '0;
				push_has    = 1'b0;
			end
		end
	end

	// Value and link memories with registered read data.
	always_ff @(posedge clk) begin
		if (val_we) begin
			value_mem[val_waddr] <= val_wdata;
		end
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (rd_en) begin
			val_rdata_q  <= value_mem[rd_addr];
			link_rdata_q <= link_mem[rd_addr];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_q <= 1'b1;
			base_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SORTED_MODE: sorted_q <= cfg_data[0];
				REG_COLUMN_BASE: base_q   <= cfg_data;
			endcase
		end
	end

	// Sequencer, list head, entry count and occupancy flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= END_CODE;
			count_q      <= '0;
			occ_q        <= '0;
			has_prev_q   <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (opcode_t'(opcode))
							OP_ADD:      state_q <= S_RND;
							OP_RETRIEVE: state_q <= S_RSTART;
							OP_CLEAR: begin
								head_q  <= END_CODE;
								count_q <= '0;
								occ_q   <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_RND: begin
					state_q <= in_range ? S_ACC : S_IDLE;
				end
				S_ACC: begin
					has_prev_q <= !head_stop;
					if (occ_q[off_idx]) begin
						state_q <= S_IDLE;
					end else if (!sorted_q) begin
						occ_q[off_idx] <= 1'b1;
						count_q        <= count_q + 1'b1;
						head_q         <= LINK_W'(off_idx);
						state_q        <= S_IDLE;
					end else if (head_stop) begin
						state_q <= S_INS;
					end else begin
						state_q <= S_SWALK;
					end
				end
				S_SWALK: begin
					if (link_stop) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					occ_q[off_idx] <= 1'b1;
					count_q        <= count_q + 1'b1;
					if (has_prev_q) begin
						state_q <= S_INS_PREV;
					end else begin
						head_q  <= LINK_W'(off_idx);
						state_q <= S_IDLE;
					end
				end
				S_INS_PREV: begin
					state_q <= S_IDLE;
				end
				S_RSTART: begin
					state_q <= (head_q < END_CODE) ? S_RDATA : S_RFIN;
				end
				S_RDATA: begin
					if (!rd_blocked) begin
						if (rd_nonzero) begin
							pend_valid_q <= 1'b1;
						end
						if (link_rdata_q >= END_CODE) begin
							state_q <= S_RFIN;
						end
					end
				end
				S_RFIN: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1    <= 64'(entry_value) * 64'(coefficient);
			off_full_q <= column - base_q;
		end
		if (state_q == S_RND) begin
			prod_q <= round_sat(prod_s1);
		end
		if ((state_q == S_ACC) && !head_stop) begin
			prev_q <= head_q[OFF_W-1:0];
		end
		if ((state_q == S_ACC) && head_stop) begin
			cur_q <= head_q;
		end
		if (state_q == S_SWALK) begin
			if (link_stop) begin
				cur_q <= link_rdata_q;
			end else begin
				prev_q <= link_rdata_q[OFF_W-1:0];
			end
		end
		if (state_q == S_RSTART) begin
			cur_q <= head_q;
		end
		if ((state_q == S_RDATA) && !rd_blocked) begin
			if (rd_nonzero) begin
				pend_col_q <= base_q + 32'(cur_q[OFF_W-1:0]);
				pend_val_q <= val_rdata_q;
			end
			cur_q <= link_rdata_q;
		end
		if (out_push) begin
			out_column_q <= push_column;
			out_value_q  <= push_value;
			has_entry_q  <= push_has;
			last_q       <= push_last;
		end
	end

	// The entry count always equals the number of occupied columns.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == COUNT_W'($countones(occ_q)))
		else $error("entry count differs from occupancy");

	// The list is empty exactly when no entry is counted.
	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == END_CODE) == (count_q == '0))
		else $error("list head disagrees with entry count");

	// A non-empty list starts at an occupied column.
	a_head_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q < END_CODE) |-> occ_q[head_q[OFF_W-1:0]])
		else $error("list head points at a free column");

	// A held entry exists only while a retrieve walks the list.
	a_pend_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> ((state_q == S_RDATA) || (state_q == S_RFIN)))
		else $error("pending entry outside a retrieve");

	// The empty-row marker is the last result and carries zeros.
	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_entry) |-> (last && (out_value == '0) && (out_column == '0)))
		else $error("malformed empty-row marker");

endmodule

`default_nettype wire
